[rtl/slr_pkg.sv]
// slr_pkg: widths, default parameters and column-sum record for the regression block.
// Used by slr_front, slr_queue, slr_back and simple_linear_regression.
package slr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 17;
  localparam int SX_W     = 33;
  localparam int SXY_W    = 48;
  localparam int SXX_W    = 47;
  localparam int COL_W    = 16;
  localparam int RES_W    = 32;
  localparam int OP_W     = 48;
  localparam int MAG_W    = 2 * OP_W;
  localparam int PROD_W   = MAG_W + 1;
  localparam int DEN_W    = 64;

  localparam int DEF_SAMPLE_WIDTH  = 16;
  localparam int DEF_MAX_ROWS      = 65536;
  localparam int DEF_FRACTION_BITS = 16;

  typedef struct packed {
    logic        [CNT_W-1:0] n;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic signed [SXY_W-1:0] sxy;
    logic        [SXX_W-1:0] sxx;
    logic        [COL_W-1:0] col;
  } col_sums_t;

endpackage

[rtl/simple_linear_regression.sv]
// simple_linear_regression: least-squares slope and intercept per column.
// Depends on slr_pkg, slr_front, slr_queue, slr_back.
//
// Input channel in_valid/in_stall carries x_sample, y_sample, last_row; one
// row transfers per cycle while the column queue has room. A transfer with
// last_row set closes the column: its sums go into a two-entry queue.
// Output channel out_valid/out_stall carries slope, intercept (signed Q with
// FRACTION_BITS fraction bits, saturated), degenerate and column_index.
// Per column the back end runs six bit-serial products on the shared serial
// multiplier, one subtraction step, and two restoring divisions on the shared
// divider. Rows keep streaming at one per cycle until two finished columns
// wait; then in_stall rises.
// A stalled result holds on the output registers, and the back end takes the
// next column only after it transfers. Synchronous reset clears the sums,
// the column counter, the queue and the output valid.
module simple_linear_regression #(
  parameter int SAMPLE_WIDTH  = slr_pkg::DEF_SAMPLE_WIDTH,
  parameter int MAX_ROWS      = slr_pkg::DEF_MAX_ROWS,
  parameter int FRACTION_BITS = slr_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [slr_pkg::SAMPLE_W-1:0] x_sample,
  input  logic        [slr_pkg::SAMPLE_W-1:0] y_sample,
  input  logic                               last_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [slr_pkg::RES_W-1:0]   slope,
  output logic signed [slr_pkg::RES_W-1:0]   intercept,
  output logic                               degenerate,
  output logic        [slr_pkg::COL_W-1:0]   column_index
);

  logic               q_full, push, q_valid, pop;
  slr_pkg::col_sums_t push_data, pop_data;

  slr_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .x_sample(x_sample), .y_sample(y_sample), .last_row(last_row),
    .q_full(q_full), .push(push), .push_data(push_data)
  );

  slr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .valid(q_valid), .pop_data(pop_data)
  );

  slr_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(pop_data), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .slope(slope),
    .intercept(intercept), .degenerate(degenerate), .column_index(column_index)
  );

endmodule

[rtl/slr_front.sv]
// slr_front: accumulates row count and sums of one column, one row per transfer.
// Depends on slr_pkg; pushes finished column sums into slr_queue.
module slr_front #(
  parameter int SAMPLE_WIDTH = slr_pkg::DEF_SAMPLE_WIDTH,
  parameter int MAX_ROWS     = slr_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [slr_pkg::SAMPLE_W-1:0]  x_sample,
  input  logic [slr_pkg::SAMPLE_W-1:0]  y_sample,
  input  logic                          last_row,
  input  logic                          q_full,
  output logic                          push,
  output slr_pkg::col_sums_t            push_data
);

  logic        [slr_pkg::CNT_W-1:0] row_count, row_count_next;
  logic signed [slr_pkg::SX_W-1:0]  sum_x, sum_x_next, sum_y, sum_y_next;
  logic signed [slr_pkg::SXY_W-1:0] sum_xy, sum_xy_next;
  logic        [slr_pkg::SXX_W-1:0] sum_xx, sum_xx_next;
  logic        [slr_pkg::COL_W-1:0] column_counter;
  logic signed [15:0]               xs, ys;
  logic signed [31:0]               xy_p, xx_p;
  logic                             take;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;
  assign xs       = 16'(signed'(x_sample[SAMPLE_WIDTH-1:0]));
  assign ys       = 16'(signed'(y_sample[SAMPLE_WIDTH-1:0]));
  assign xy_p     = xs * ys;
  assign xx_p     = xs * xs;

  always_comb begin
    row_count_next = row_count;
    sum_x_next     = sum_x;
    sum_y_next     = sum_y;
    sum_xy_next    = sum_xy;
    sum_xx_next    = sum_xx;
    if (row_count < slr_pkg::CNT_W'(MAX_ROWS)) begin
      row_count_next = row_count + 1'b1;
      sum_x_next     = sum_x + slr_pkg::SX_W'(xs);
      sum_y_next     = sum_y + slr_pkg::SX_W'(ys);
      sum_xy_next    = sum_xy + slr_pkg::SXY_W'(xy_p);
      sum_xx_next    = sum_xx + slr_pkg::SXX_W'($unsigned(xx_p));
    end
  end

  assign push           = take && last_row;
  assign push_data.n    = row_count_next;
  assign push_data.sx   = sum_x_next;
  assign push_data.sy   = sum_y_next;
  assign push_data.sxy  = sum_xy_next;
  assign push_data.sxx  = sum_xx_next;
  assign push_data.col  = column_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= '0;
      sum_x          <= '0;
      sum_y          <= '0;
      sum_xy         <= '0;
      sum_xx         <= '0;
      column_counter <= '0;
    end else if (take) begin
      if (last_row) begin
        row_count      <= '0;
        sum_x          <= '0;
        sum_y          <= '0;
        sum_xy         <= '0;
        sum_xx         <= '0;
        column_counter <= column_counter + 1'b1;
      end else begin
        row_count <= row_count_next;
        sum_x     <= sum_x_next;
        sum_y     <= sum_y_next;
        sum_xy    <= sum_xy_next;
        sum_xx    <= sum_xx_next;
      end
    end
  end

endmodule

[rtl/slr_queue.sv]
// slr_queue: two-entry queue of finished column sums between front and back.
// Depends on slr_pkg.
module slr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  slr_pkg::col_sums_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output slr_pkg::col_sums_t pop_data
);

  slr_pkg::col_sums_t mem [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[rtl/slr_back.sv]
// slr_back: per-column solver; bit-serial multiplier for the six products and a
// restoring divider for slope and intercept. Depends on slr_pkg.
module slr_back #(
  parameter int FRACTION_BITS = slr_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  slr_pkg::col_sums_t                 q_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [slr_pkg::RES_W-1:0]   slope,
  output logic signed [slr_pkg::RES_W-1:0]   intercept,
  output logic                               degenerate,
  output logic        [slr_pkg::COL_W-1:0]   column_index
);

  localparam int MAG_W = slr_pkg::MAG_W;
  localparam int PW    = slr_pkg::PROD_W;
  localparam int OPW   = slr_pkg::OP_W;
  localparam int DW    = slr_pkg::DEN_W;
  localparam int DVW   = MAG_W + FRACTION_BITS;
  localparam int MCW   = $clog2(OPW);
  localparam int DCW   = $clog2(DVW);
  localparam int RES_W_L = slr_pkg::RES_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_SUB, S_DLOAD, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t                  state;
  slr_pkg::col_sums_t      cs;
  logic [2:0]              idx;
  logic [MCW-1:0]          mcnt;
  logic [MAG_W-1:0]        a_sh, acc, acc_next;
  logic [OPW-1:0]          b_sh;
  logic                    mneg;
  logic signed [PW-1:0]    prod [6];
  logic signed [PW-1:0]    den, num_s, num_i;
  logic signed [PW-1:0]    num_sel;
  logic signed [OPW:0]     op_a, op_b;
  logic                    div_sel, dneg, big;
  logic [DVW-1:0]          dv;
  logic [DCW-1:0]          dcnt;
  logic [DW-1:0]           rem, rem_next;
  logic [32:0]             quo, quo_next, qf;
  logic                    qbit;
  logic [DW:0]             trial;
  logic [RES_W_L-1:0]      res;

  assign pop = (state == S_IDLE) && q_valid;

  always_comb begin
    case (idx)
      3'd0:    begin op_a = (OPW+1)'(signed'({1'b0, cs.n}));   op_b = (OPW+1)'(signed'({1'b0, cs.sxx})); end
      3'd1:    begin op_a = (OPW+1)'(cs.sx);                   op_b = (OPW+1)'(cs.sx);                   end
      3'd2:    begin op_a = (OPW+1)'(signed'({1'b0, cs.n}));   op_b = (OPW+1)'(cs.sxy);                  end
      3'd3:    begin op_a = (OPW+1)'(cs.sx);                   op_b = (OPW+1)'(cs.sy);                   end
      3'd4:    begin op_a = (OPW+1)'(cs.sy);                   op_b = (OPW+1)'(signed'({1'b0, cs.sxx})); end
      default: begin op_a = (OPW+1)'(cs.sx);                   op_b = (OPW+1)'(cs.sxy);                  end
    endcase
  end

  assign acc_next = b_sh[0] ? acc + a_sh : acc;
  assign num_sel  = div_sel ? num_i : num_s;

  always_comb begin
    trial    = {rem, dv[DVW-1]};
    qbit     = (trial >= {1'b0, den[DW-1:0]});
    rem_next = qbit ? DW'(trial - {1'b0, den[DW-1:0]}) : trial[DW-1:0];
    quo_next = {quo[31:0], qbit};
  end

  always_comb begin
    qf = quo;
    if (!big && ({rem, 1'b0} >= {1'b0, den[DW-1:0]})) qf = quo + 1'b1;
    if (big || qf > (dneg ? 33'h080000000 : 33'h07FFFFFFF)) begin
      qf = dneg ? 33'h080000000 : 33'h07FFFFFFF;
    end
    res = dneg ? RES_W_L'(-qf[31:0]) : qf[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cs           <= q_data;
            column_index <= q_data.col;
            idx          <= '0;
            state        <= S_LOAD;
          end
        end
        S_LOAD: begin
          a_sh  <= MAG_W'(op_a[OPW] ? OPW'(-op_a) : op_a[OPW-1:0]);
          b_sh  <= op_b[OPW] ? OPW'(-op_b) : op_b[OPW-1:0];
          mneg  <= op_a[OPW] ^ op_b[OPW];
          acc   <= '0;
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          acc  <= acc_next;
          a_sh <= a_sh << 1;
          b_sh <= b_sh >> 1;
          mcnt <= mcnt + 1'b1;
          if (mcnt == MCW'(OPW-1)) begin
            prod[idx] <= mneg ? -signed'({1'b0, acc_next}) : signed'({1'b0, acc_next});
            if (idx == 3'd5) begin
              state <= S_SUB;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_SUB: begin
          den     <= prod[0] - prod[1];
          num_s   <= prod[2] - prod[3];
          num_i   <= prod[4] - prod[5];
          div_sel <= 1'b0;
          if (prod[0] - prod[1] <= 0) begin
            slope      <= '0;
            intercept  <= '0;
            degenerate <= 1'b1;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            degenerate <= 1'b0;
            state      <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          dneg  <= num_sel[PW-1];
          dv    <= {(num_sel[PW-1] ? MAG_W'(-num_sel) : num_sel[MAG_W-1:0]),
                    {FRACTION_BITS{1'b0}}};
          rem   <= '0;
          quo   <= '0;
          big   <= 1'b0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_next;
          dv   <= dv << 1;
          dcnt <= dcnt + 1'b1;
          if (!big) begin
            quo <= quo_next;
            big <= quo_next[32];
          end
          if (dcnt == DCW'(DVW-1)) state <= S_FIN;
        end
        S_FIN: begin
          if (!div_sel) begin
            slope   <= res;
            div_sel <= 1'b1;
            state   <= S_DLOAD;
          end else begin
            intercept <= res;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (slope == 0 && intercept == 0))
    else $error("degenerate result with nonzero outputs");
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result valid outside output state");
  a_pop_start: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_LOAD))
    else $error("pop did not start a column");
`endif

endmodule
